// File: design/srcb_pkg.sv
// ----------------------------------------------------------------------------
// srcb_pkg
// Shared widths, register indexes, key codes and reset values for the
// speed ramp with collision brake.
// ----------------------------------------------------------------------------
package srcb_pkg;

  localparam int unsigned MAX_SAMPLES = 1024;

  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 20;
  localparam int KEY_WIDTH       = 8;
  localparam int INDEX_WIDTH     = 10;
  localparam int DIST_WIDTH      = 20;
  localparam int STEP_WIDTH      = 8;
  localparam int SPEED_WIDTH     = 9;
  localparam int TARGET_WIDTH    = 10;
  localparam int CALC_WIDTH      = 11;

  typedef logic [CFG_INDEX_WIDTH-1:0] reg_index_t;

  localparam reg_index_t REG_STOP_DISTANCE   = 3'd0;
  localparam reg_index_t REG_LINEAR_STEP     = 3'd1;
  localparam reg_index_t REG_ANGULAR_STEP    = 3'd2;
  localparam reg_index_t REG_BRAKE_START     = 3'd3;
  localparam reg_index_t REG_BRAKE_INCREMENT = 3'd4;
  localparam reg_index_t REG_WINDOW_FIRST    = 3'd5;
  localparam reg_index_t REG_WINDOW_LAST     = 3'd6;

  // operation field of an input transaction
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [KEY_WIDTH-1:0] KEY_W_UPPER = 8'h57;
  localparam logic [KEY_WIDTH-1:0] KEY_W_LOWER = 8'h77;
  localparam logic [KEY_WIDTH-1:0] KEY_S_UPPER = 8'h53;
  localparam logic [KEY_WIDTH-1:0] KEY_S_LOWER = 8'h73;
  localparam logic [KEY_WIDTH-1:0] KEY_A_UPPER = 8'h41;
  localparam logic [KEY_WIDTH-1:0] KEY_A_LOWER = 8'h61;
  localparam logic [KEY_WIDTH-1:0] KEY_D_UPPER = 8'h44;
  localparam logic [KEY_WIDTH-1:0] KEY_D_LOWER = 8'h64;
  localparam logic [KEY_WIDTH-1:0] KEY_Q_UPPER = 8'h51;
  localparam logic [KEY_WIDTH-1:0] KEY_Q_LOWER = 8'h71;
  localparam logic [KEY_WIDTH-1:0] KEY_SPACE   = 8'h20;

  localparam logic [DIST_WIDTH-1:0]  RST_STOP_DISTANCE   = 20'd1000;
  localparam logic [STEP_WIDTH-1:0]  RST_LINEAR_STEP     = 8'd50;
  localparam logic [STEP_WIDTH-1:0]  RST_ANGULAR_STEP    = 8'd75;
  localparam logic [STEP_WIDTH-1:0]  RST_BRAKE_START     = 8'd5;
  localparam logic [STEP_WIDTH-1:0]  RST_BRAKE_INCREMENT = 8'd10;
  localparam logic [INDEX_WIDTH-1:0] RST_WINDOW_FIRST    = 10'd0;
  localparam logic [INDEX_WIDTH-1:0] RST_WINDOW_LAST     = 10'd1023;

  localparam logic [DIST_WIDTH-1:0] FAR_MM       = 20'd999000;
  localparam logic [DIST_WIDTH-1:0] MIN_VALID_MM = 20'd50;

  localparam logic signed [CALC_WIDTH-1:0] LIN_TARGET_STEP = 11'sd250;
  localparam logic signed [CALC_WIDTH-1:0] ANG_TARGET_STEP = 11'sd150;
  localparam logic signed [CALC_WIDTH-1:0] LIN_LIMIT       = 11'sd250;
  localparam logic signed [CALC_WIDTH-1:0] ANG_LIMIT       = 11'sd150;

endpackage

// File: design/srcb_in_if.sv
// ----------------------------------------------------------------------------
// srcb_in_if
// Input channel: control ticks and range samples with valid/ready.
// ----------------------------------------------------------------------------
interface srcb_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 operation;
  logic                                 key_valid;
  logic [srcb_pkg::KEY_WIDTH-1:0]       key_code;
  logic [srcb_pkg::INDEX_WIDTH-1:0]     sample_index;
  logic [srcb_pkg::DIST_WIDTH-1:0]      sample_distance;
  logic                                 last_sample;

  modport source (
    output valid, operation, key_valid, key_code, sample_index, sample_distance,
           last_sample,
    input  ready
  );
  modport sink (
    input  valid, operation, key_valid, key_code, sample_index, sample_distance,
           last_sample,
    output ready
  );
endinterface

// File: design/srcb_out_if.sv
// ----------------------------------------------------------------------------
// srcb_out_if
// Result channel: speed commands and status with valid/ready.
// ----------------------------------------------------------------------------
interface srcb_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [srcb_pkg::SPEED_WIDTH-1:0]  linear_speed;
  logic signed [srcb_pkg::SPEED_WIDTH-1:0]  angular_speed;
  logic                                     emergency_stop;
  logic                                     halted;
  logic [srcb_pkg::DIST_WIDTH-1:0]          nearest_distance;

  modport source (
    output valid, linear_speed, angular_speed, emergency_stop, halted,
           nearest_distance,
    input  ready
  );
  modport sink (
    input  valid, linear_speed, angular_speed, emergency_stop, halted,
           nearest_distance,
    output ready
  );
endinterface

// File: design/speed_ramp_with_collision_brake_core.sv
// ----------------------------------------------------------------------------
// speed_ramp_with_collision_brake_core
// Drive-speed ramp with key control, obstacle stop and growing brake force,
// fed by a windowed nearest-range tracker.
// ----------------------------------------------------------------------------
//  channel | dir | contents
//  req     | in  | control tick (key) or range sample (index, distance, last)
//  rsp     | out | speeds, emergency stop, halted, nearest distance
//  cfg_*   | in  | register writes, no read-back
//
//  one transaction per cycle sustained while rsp takes results; a tick's result
//  passes through the input register, then the result register
//  range samples produce no result and never wait on rsp
//  a stalled result holds the output register; the next tick waits in the
//  input register and holds req off, samples ahead of it still drain
//  synchronous reset restores configuration, state and valid flags, no clearing pass
// ----------------------------------------------------------------------------
module speed_ramp_with_collision_brake_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [srcb_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [srcb_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
  srcb_in_if.sink                               req,
  srcb_out_if.source                            rsp
);

  // configuration
  logic [srcb_pkg::DIST_WIDTH-1:0]  stop_distance;
  logic [srcb_pkg::STEP_WIDTH-1:0]  linear_step;
  logic [srcb_pkg::STEP_WIDTH-1:0]  angular_step;
  logic [srcb_pkg::STEP_WIDTH-1:0]  brake_start;
  logic [srcb_pkg::STEP_WIDTH-1:0]  brake_increment;
  logic [srcb_pkg::INDEX_WIDTH-1:0] window_first;
  logic [srcb_pkg::INDEX_WIDTH-1:0] window_last;

  // state
  logic signed [srcb_pkg::TARGET_WIDTH-1:0] goal_lin;
  logic signed [srcb_pkg::TARGET_WIDTH-1:0] goal_ang;
  logic signed [srcb_pkg::SPEED_WIDTH-1:0]  speed_lin;
  logic signed [srcb_pkg::SPEED_WIDTH-1:0]  speed_ang;
  logic [srcb_pkg::STEP_WIDTH-1:0]          brake_force;
  logic                                     stop_flag;
  logic [srcb_pkg::DIST_WIDTH-1:0]          committed_nearest;
  logic [srcb_pkg::DIST_WIDTH-1:0]          window_minimum;

  // input register
  logic                                 stage_valid;
  logic                                 stage_operation;
  logic                                 stage_key_valid;
  logic [srcb_pkg::KEY_WIDTH-1:0]       stage_key_code;
  logic [srcb_pkg::INDEX_WIDTH-1:0]     stage_sample_index;
  logic [srcb_pkg::DIST_WIDTH-1:0]      stage_sample_distance;
  logic                                 stage_last_sample;
  logic                                 stage_fire;

  // result register
  logic                                     rsp_valid;
  logic signed [srcb_pkg::SPEED_WIDTH-1:0]  rsp_linear_speed;
  logic signed [srcb_pkg::SPEED_WIDTH-1:0]  rsp_angular_speed;
  logic                                     rsp_emergency_stop;
  logic                                     rsp_halted;
  logic [srcb_pkg::DIST_WIDTH-1:0]          rsp_nearest_distance;

  // tick datapath
  logic                                   key_lin_up, key_lin_down;
  logic                                   key_ang_up, key_ang_down;
  logic                                   key_clear, key_quit;
  logic signed [srcb_pkg::CALC_WIDTH-1:0] tl_key, ta_key, tl_obs;
  logic signed [srcb_pkg::CALC_WIDTH-1:0] tl_clamp, ta_clamp;
  logic signed [srcb_pkg::CALC_WIDTH-1:0] cl_calc, cl_new, ca_new;
  logic                                   close_range, forward;
  logic                                   stop_flag_next;
  logic                                   braking;
  logic [srcb_pkg::STEP_WIDTH:0]          force_sum;
  logic [srcb_pkg::STEP_WIDTH-1:0]        force_sat;
  logic [srcb_pkg::STEP_WIDTH-1:0]        brake_force_next;

  // sample datapath
  logic                                   sample_counts;
  logic [srcb_pkg::DIST_WIDTH-1:0]        window_minimum_next;

  function automatic logic signed [srcb_pkg::CALC_WIDTH-1:0] ramp(
    input logic signed [srcb_pkg::CALC_WIDTH-1:0] cur,
    input logic signed [srcb_pkg::CALC_WIDTH-1:0] tgt,
    input logic [srcb_pkg::STEP_WIDTH-1:0]        step
  );
    logic signed [srcb_pkg::CALC_WIDTH-1:0] s;
    logic signed [srcb_pkg::CALC_WIDTH-1:0] r;
    s = $signed({{(srcb_pkg::CALC_WIDTH-srcb_pkg::STEP_WIDTH){1'b0}}, step});
    r = cur;
    if (cur < tgt) begin
      r = cur + s;
      if (r > tgt) r = tgt;
    end else if (cur > tgt) begin
      r = cur - s;
      if (r < tgt) r = tgt;
    end
    return r;
  endfunction

  // handshake: samples always drain, ticks need room in the result register
  assign stage_fire = stage_valid && ((stage_operation == srcb_pkg::OP_SAMPLE)
                                      || !rsp_valid || rsp.ready);
  assign req.ready  = !stage_valid || stage_fire;

  assign rsp.valid            = rsp_valid;
  assign rsp.linear_speed     = rsp_linear_speed;
  assign rsp.angular_speed    = rsp_angular_speed;
  assign rsp.emergency_stop   = rsp_emergency_stop;
  assign rsp.halted           = rsp_halted;
  assign rsp.nearest_distance = rsp_nearest_distance;

  // key decode
  always_comb begin
    key_lin_up   = 1'b0;
    key_lin_down = 1'b0;
    key_ang_up   = 1'b0;
    key_ang_down = 1'b0;
    key_clear    = 1'b0;
    key_quit     = 1'b0;
    if (stage_key_valid) begin
      unique case (stage_key_code) inside
        srcb_pkg::KEY_W_UPPER, srcb_pkg::KEY_W_LOWER: key_lin_up   = 1'b1;
        srcb_pkg::KEY_S_UPPER, srcb_pkg::KEY_S_LOWER: key_lin_down = 1'b1;
        srcb_pkg::KEY_A_UPPER, srcb_pkg::KEY_A_LOWER: key_ang_up   = 1'b1;
        srcb_pkg::KEY_D_UPPER, srcb_pkg::KEY_D_LOWER: key_ang_down = 1'b1;
        srcb_pkg::KEY_SPACE:                          key_clear    = 1'b1;
        srcb_pkg::KEY_Q_UPPER, srcb_pkg::KEY_Q_LOWER: key_quit     = 1'b1;
        default: ;
      endcase
    end
  end

  // targets, obstacle check, clamp, brake and ramp
  always_comb begin
    tl_key = srcb_pkg::CALC_WIDTH'(goal_lin);
    ta_key = srcb_pkg::CALC_WIDTH'(goal_ang);
    if (key_lin_up)   tl_key = tl_key + srcb_pkg::LIN_TARGET_STEP;
    if (key_lin_down) tl_key = tl_key - srcb_pkg::LIN_TARGET_STEP;
    if (key_ang_up)   ta_key = ta_key + srcb_pkg::ANG_TARGET_STEP;
    if (key_ang_down) ta_key = ta_key - srcb_pkg::ANG_TARGET_STEP;
    if (key_clear) begin
      tl_key = '0;
      ta_key = '0;
    end

    close_range    = committed_nearest <= stop_distance;
    forward        = (tl_key > 0) || (speed_lin > 0);
    tl_obs         = tl_key;
    stop_flag_next = stop_flag;
    if (close_range) begin
      if (forward) begin
        tl_obs         = '0;
        stop_flag_next = 1'b1;
      end
    end else begin
      stop_flag_next = 1'b0;
    end

    tl_clamp = tl_obs;
    if (tl_obs > srcb_pkg::LIN_LIMIT)  tl_clamp = srcb_pkg::LIN_LIMIT;
    if (tl_obs < -srcb_pkg::LIN_LIMIT) tl_clamp = -srcb_pkg::LIN_LIMIT;
    ta_clamp = ta_key;
    if (ta_key > srcb_pkg::ANG_LIMIT)  ta_clamp = srcb_pkg::ANG_LIMIT;
    if (ta_key < -srcb_pkg::ANG_LIMIT) ta_clamp = -srcb_pkg::ANG_LIMIT;

    cl_calc   = srcb_pkg::CALC_WIDTH'(speed_lin);
    braking   = (tl_clamp == 0) && (speed_lin != 0);
    force_sum = {1'b0, brake_force} + {1'b0, brake_increment};
    force_sat = force_sum[srcb_pkg::STEP_WIDTH] ? '1 : force_sum[srcb_pkg::STEP_WIDTH-1:0];
    if (braking) begin
      brake_force_next = force_sat;
      cl_new           = ramp(cl_calc, '0, force_sat);
    end else begin
      brake_force_next = brake_start;
      cl_new           = ramp(cl_calc, tl_clamp, linear_step);
    end
    ca_new = ramp(srcb_pkg::CALC_WIDTH'(speed_ang), ta_clamp, angular_step);
  end

  // running window minimum
  always_comb begin
    sample_counts = (stage_sample_index >= window_first)
                 && (stage_sample_index <= window_last)
                 && (32'(stage_sample_index) < srcb_pkg::MAX_SAMPLES)
                 && (stage_sample_distance > srcb_pkg::MIN_VALID_MM)
                 && (stage_sample_distance < window_minimum);
    window_minimum_next = sample_counts ? stage_sample_distance : window_minimum;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stop_distance   <= srcb_pkg::RST_STOP_DISTANCE;
      linear_step     <= srcb_pkg::RST_LINEAR_STEP;
      angular_step    <= srcb_pkg::RST_ANGULAR_STEP;
      brake_start     <= srcb_pkg::RST_BRAKE_START;
      brake_increment <= srcb_pkg::RST_BRAKE_INCREMENT;
      window_first    <= srcb_pkg::RST_WINDOW_FIRST;
      window_last     <= srcb_pkg::RST_WINDOW_LAST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        srcb_pkg::REG_STOP_DISTANCE:   stop_distance   <= cfg_data[srcb_pkg::DIST_WIDTH-1:0];
        srcb_pkg::REG_LINEAR_STEP:     linear_step     <= cfg_data[srcb_pkg::STEP_WIDTH-1:0];
        srcb_pkg::REG_ANGULAR_STEP:    angular_step    <= cfg_data[srcb_pkg::STEP_WIDTH-1:0];
        srcb_pkg::REG_BRAKE_START:     brake_start     <= cfg_data[srcb_pkg::STEP_WIDTH-1:0];
        srcb_pkg::REG_BRAKE_INCREMENT: brake_increment <= cfg_data[srcb_pkg::STEP_WIDTH-1:0];
        srcb_pkg::REG_WINDOW_FIRST:    window_first    <= cfg_data[srcb_pkg::INDEX_WIDTH-1:0];
        srcb_pkg::REG_WINDOW_LAST:     window_last     <= cfg_data[srcb_pkg::INDEX_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      stage_valid <= 1'b1;
    end else if (stage_fire) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      stage_operation       <= req.operation;
      stage_key_valid       <= req.key_valid;
      stage_key_code        <= req.key_code;
      stage_sample_index    <= req.sample_index;
      stage_sample_distance <= req.sample_distance;
      stage_last_sample     <= req.last_sample;
    end
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      goal_lin          <= '0;
      goal_ang          <= '0;
      speed_lin         <= '0;
      speed_ang         <= '0;
      brake_force       <= srcb_pkg::RST_BRAKE_START;
      stop_flag         <= 1'b0;
      committed_nearest <= srcb_pkg::FAR_MM;
      window_minimum    <= srcb_pkg::FAR_MM;
    end else if (stage_fire) begin
      if (stage_operation == srcb_pkg::OP_SAMPLE) begin
        if (stage_last_sample) begin
          committed_nearest <= window_minimum_next;
          window_minimum    <= srcb_pkg::FAR_MM;
        end else begin
          window_minimum    <= window_minimum_next;
        end
      end else if (key_quit) begin
        goal_lin    <= '0;
        goal_ang    <= '0;
        speed_lin   <= '0;
        speed_ang   <= '0;
        stop_flag   <= 1'b0;
        brake_force <= brake_start;
      end else begin
        goal_lin    <= tl_clamp[srcb_pkg::TARGET_WIDTH-1:0];
        goal_ang    <= ta_clamp[srcb_pkg::TARGET_WIDTH-1:0];
        speed_lin   <= cl_new[srcb_pkg::SPEED_WIDTH-1:0];
        speed_ang   <= ca_new[srcb_pkg::SPEED_WIDTH-1:0];
        stop_flag   <= stop_flag_next;
        brake_force <= brake_force_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (stage_fire && (stage_operation == srcb_pkg::OP_TICK)) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_fire && (stage_operation == srcb_pkg::OP_TICK)) begin
      rsp_nearest_distance <= committed_nearest;
      rsp_halted           <= key_quit;
      if (key_quit) begin
        rsp_linear_speed   <= '0;
        rsp_angular_speed  <= '0;
        rsp_emergency_stop <= 1'b0;
      end else begin
        rsp_linear_speed   <= cl_new[srcb_pkg::SPEED_WIDTH-1:0];
        rsp_angular_speed  <= ca_new[srcb_pkg::SPEED_WIDTH-1:0];
        rsp_emergency_stop <= stop_flag_next;
      end
    end
  end

endmodule
